/* sv/gkis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gkis_pkg;

    localparam int CAPACITY    = 32;
    localparam int HANDLE_BITS = 5;
    localparam int KEY_BITS    = 54;
    localparam int RANK_BITS   = 2;

    localparam logic [RANK_BITS-1:0] RANK_OTHER = 2'd2;

    typedef struct packed {
        logic                   valid;
        logic [RANK_BITS-1:0]   rank;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage
`default_nettype wire

/* sv/gkis_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module gkis_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  gkis_pkg::cell_ctrl_t    ctrl,
    input  gkis_pkg::entry_t        new_entry,
    input  gkis_pkg::entry_t        prev_entry,
    input  wire logic               prev_after,
    input  gkis_pkg::entry_t        next_entry,
    output gkis_pkg::entry_t        entry,
    output logic                    after
);
    import gkis_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [RANK_BITS-1:0]   rank_reg;
    logic [RANK_BITS-1:0]   rank_next;
    logic [KEY_BITS-1:0]    key_reg;
    logic [KEY_BITS-1:0]    key_next;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [HANDLE_BITS-1:0] handle_next;

    // stored entry stays ahead of the new one (equal keys keep arrival order)
    always_comb
    begin
        if (rank_reg != new_entry.rank)
        begin
            after = valid_reg && (rank_reg < new_entry.rank);
        end
        else
        begin
            after = valid_reg && (key_reg <= new_entry.key);
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        rank_next   = rank_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctrl.pop)
        begin
            // advance toward the head
            valid_next  = next_entry.valid;
            rank_next   = next_entry.rank;
            key_next    = next_entry.key;
            handle_next = next_entry.handle;
        end
        else if (ctrl.insert && !after)
        begin
            if (prev_after)
            begin
                valid_next  = 1'b1;
                rank_next   = new_entry.rank;
                key_next    = new_entry.key;
                handle_next = new_entry.handle;
            end
            else
            begin
                valid_next  = prev_entry.valid;
                rank_next   = prev_entry.rank;
                key_next    = prev_entry.key;
                handle_next = prev_entry.handle;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg   <= rank_next;
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign entry.valid  = valid_reg;
    assign entry.rank   = rank_reg;
    assign entry.key    = key_reg;
    assign entry.handle = handle_reg;

endmodule
`default_nettype wire

/* sv/grouped_key_insertion_sorter.sv */
// Sorts a set of entries by group rank, then ascending key, keeping arrival
// order among equal keys. Entries stream in at one per cycle: a row of
// CAPACITY cells compares every stored entry with the arriving one in
// parallel and shifts the tail right by one in that same cycle. The entry
// flagged final_entry starts emission; while the run drains, in_ready is low
// and the row shifts toward the head one beat per accepted output, so a run
// of N entries leaves in N beats, after which the block takes input again.
// Entries arriving at a full row are dropped and every beat of that run
// shows dropped_any.
`timescale 1ns / 1ps
`default_nettype none
module grouped_key_insertion_sorter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    category,
    input  wire logic [gkis_pkg::KEY_BITS-1:0] entry_key,
    input  wire logic [gkis_pkg::HANDLE_BITS-1:0] handle,
    input  wire logic                          final_entry,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         out_category,
    output logic [gkis_pkg::KEY_BITS-1:0]      out_key,
    output logic [gkis_pkg::HANDLE_BITS-1:0]   out_handle,
    output logic                               end_of_run,
    output logic                               dropped_any
);
    import gkis_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       overflow_reg;
    logic       overflow_next;
    logic       in_fire;
    logic       out_fire;
    logic       full;
    cell_ctrl_t ctrl;
    entry_t     new_entry;
    entry_t     cells [CAPACITY+1];
    logic       after [CAPACITY+1];

    assign in_ready = (state_reg == ST_FILL);
    assign in_fire  = in_valid && in_ready;
    assign full     = cells[CAPACITY-1].valid;

    // code 3 falls into the "others" group
    assign new_entry.valid  = 1'b1;
    assign new_entry.rank   = (category > RANK_OTHER) ? RANK_OTHER : category;
    assign new_entry.key    = entry_key;
    assign new_entry.handle = handle;

    assign ctrl.insert = in_fire && !full;
    assign ctrl.pop    = out_fire;

    // head cell always sees a slot before it; the tail reads an empty slot
    assign after[0]  = 1'b1;
    assign cells[CAPACITY] = '0;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                gkis_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .new_entry  (new_entry),
                    .prev_entry (new_entry),
                    .prev_after (after[0]),
                    .next_entry (cells[1]),
                    .entry      (cells[0]),
                    .after      (after[1])
                );
            end
            else
            begin : g_body
                gkis_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .new_entry  (new_entry),
                    .prev_entry (cells[i-1]),
                    .prev_after (after[i]),
                    .next_entry (cells[i+1]),
                    .entry      (cells[i]),
                    .after      (after[i+1])
                );
            end
        end
    endgenerate

    assign out_valid    = (state_reg == ST_DRAIN) && cells[0].valid;
    assign out_fire     = out_valid && out_ready;
    assign out_category = cells[0].rank;
    assign out_key      = cells[0].key;
    assign out_handle   = cells[0].handle;
    assign end_of_run   = !cells[1].valid;
    assign dropped_any  = overflow_reg;

    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (in_fire && full)
                begin
                    overflow_next = 1'b1;
                end
                if (in_fire && final_entry)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_fire && end_of_run)
                begin
                    overflow_next = 1'b0;
                    state_next    = ST_FILL;
                end
            end
            default:
            begin
                state_next    = ST_FILL;
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule
`default_nettype wire

/* sv/gkis_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module gkis_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          final_entry,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [gkis_pkg::KEY_BITS-1:0] out_key,
    input wire logic                          end_of_run,
    input wire logic                          dropped_any
);
    import gkis_pkg::*;

    // input is held off while a run drains
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted during drain");

    a_final_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && final_entry) |=> out_valid)
        else $error("final beat did not start emission");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !end_of_run) |=> (out_valid && $stable(dropped_any)))
        else $error("run broke off before its last beat");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && end_of_run) |=> (!out_valid && in_ready))
        else $error("output after end of run");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_key)))
        else $error("stalled output beat changed");

endmodule

bind grouped_key_insertion_sorter gkis_checker u_gkis_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .final_entry (final_entry),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_key     (out_key),
    .end_of_run  (end_of_run),
    .dropped_any (dropped_any)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import gkis_pkg::*;

    localparam logic [RANK_BITS-1:0] RANK_FIRST  = 2'd0;
    localparam logic [RANK_BITS-1:0] RANK_SECOND = 2'd1;
    localparam logic [RANK_BITS-1:0] CAT_UNUSED  = 2'd3;
    localparam logic [KEY_BITS-1:0]  KEY_ALL_ONES = {KEY_BITS{1'b1}};
    localparam logic [KEY_BITS-1:0]  KEY_DEC_MAX  = 54'd9999999999999999;
    localparam logic [63:0]          KEY_DEC_SPAN = 64'd10000000000000000;
    localparam int                   CYCLE_LIMIT  = 200000;
    localparam int                   DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [RANK_BITS-1:0]   rank;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] hnd;
    } slot_t;

    typedef struct packed {
        logic [RANK_BITS-1:0]   cat;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] hnd;
        logic                   last;
        logic                   drop;
    } sorted_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             category = '0;
    logic [KEY_BITS-1:0]    entry_key = '0;
    logic [HANDLE_BITS-1:0] handle = '0;
    logic                   final_entry = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             out_category;
    logic [KEY_BITS-1:0]    out_key;
    logic [HANDLE_BITS-1:0] out_handle;
    logic                   end_of_run;
    logic                   dropped_any;

    // shadow of the sorted row
    slot_t        shadow_row [CAPACITY];
    int           shadow_fill = 0;
    bit           shadow_overflow = 1'b0;
    sorted_beat_t sorted_q [$];

    int  errors = 0;
    int  cycle_count = 0;
    int  in_idle_pct = 0;
    int  out_stall_pct = 0;

    grouped_key_insertion_sorter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .category     (category),
        .entry_key    (entry_key),
        .handle       (handle),
        .final_entry  (final_entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_category (out_category),
        .out_key      (out_key),
        .out_handle   (out_handle),
        .end_of_run   (end_of_run),
        .dropped_any  (dropped_any)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Insert one entry into the shadow row; on the final mark queue the whole run.
    function automatic void insert_and_emit(input logic [1:0] cat,
                                            input logic [KEY_BITS-1:0] key,
                                            input logic [HANDLE_BITS-1:0] hnd,
                                            input logic fin);
        logic [RANK_BITS-1:0] rank;
        int                   pos;
        int                   i;
        sorted_beat_t         beat;
        rank = (cat == CAT_UNUSED) ? RANK_OTHER : cat;
        if (shadow_fill >= CAPACITY)
            shadow_overflow = 1'b1;
        else
        begin
            pos = 0;
            while (pos < shadow_fill &&
                   (shadow_row[pos].rank < rank ||
                    (shadow_row[pos].rank == rank && shadow_row[pos].key <= key)))
                pos++;
            for (i = shadow_fill; i > pos; i--)
                shadow_row[i] = shadow_row[i-1];
            shadow_row[pos] = '{rank: rank, key: key, hnd: hnd};
            shadow_fill++;
        end
        if (fin)
        begin
            for (i = 0; i < shadow_fill; i++)
            begin
                beat.cat  = shadow_row[i].rank;
                beat.key  = shadow_row[i].key;
                beat.hnd  = shadow_row[i].hnd;
                beat.last = (i == shadow_fill - 1);
                beat.drop = shadow_overflow;
                sorted_q.insert(sorted_q.size(), beat);
            end
            shadow_fill     = 0;
            shadow_overflow = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            insert_and_emit(category, entry_key, handle, final_entry);
    end

    always @(posedge clk)
    begin
        sorted_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sorted_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected beat cat=%0d key=%0d handle=%0d eor=%0b drop=%0b",
                             out_category, out_key, out_handle, end_of_run, dropped_any);
            end
            else
            begin
                want = sorted_q.pop_front();
                if (out_category !== want.cat || out_key !== want.key ||
                    out_handle !== want.hnd || end_of_run !== want.last ||
                    dropped_any !== want.drop)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                                 want.cat, want.key, want.hnd, want.last, want.drop,
                                 out_category, out_key, out_handle, end_of_run, dropped_any);
                end
            end
        end
    end

    // Drive one entry and hold it until the block takes it; valid stays up afterward.
    task automatic send_entry(input logic [1:0] cat, input logic [KEY_BITS-1:0] key,
                              input logic [HANDLE_BITS-1:0] hnd, input logic fin);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        category    <= cat;
        entry_key   <= key;
        handle      <= hnd;
        final_entry <= fin;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
    endtask

    function automatic logic [KEY_BITS-1:0] random_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(4))
            0: return KEY_BITS'($urandom_range(7));
            1, 2: return raw[KEY_BITS-1:0];
            3: return KEY_BITS'(raw % KEY_DEC_SPAN);
            default: return ($urandom_range(1) != 0) ? KEY_ALL_ONES : KEY_DEC_MAX;
        endcase
    endfunction

    function automatic logic [1:0] random_category();
        return 2'($urandom_range(3));
    endfunction

    task automatic send_random_set(input int size);
        int n;
        for (n = 0; n < size; n++)
            send_entry(random_category(), random_key(), HANDLE_BITS'($urandom),
                       n == size - 1);
    endtask

    task automatic test_extremes();
        send_entry(RANK_OTHER,  KEY_ALL_ONES, 5'd31, 1'b0);
        send_entry(CAT_UNUSED,  '0,           5'd0,  1'b0);
        send_entry(RANK_SECOND, KEY_DEC_MAX,  5'd21, 1'b0);
        send_entry(RANK_FIRST,  KEY_ALL_ONES, 5'd10, 1'b0);
        send_entry(RANK_FIRST,  '0,           5'd31, 1'b0);
        send_entry(RANK_SECOND, '0,           5'd1,  1'b0);
        send_entry(CAT_UNUSED,  KEY_DEC_MAX,  5'd30, 1'b1);
        // a run of one
        send_entry(RANK_SECOND, 54'h2AAAAAAAAAAAAA, 5'd21, 1'b1);
    endtask

    task automatic test_stable_order();
        // equal rank and key must come out in arrival order; code 3 ties with rank 2
        send_entry(RANK_OTHER,  54'd500, 5'd1, 1'b0);
        send_entry(CAT_UNUSED,  54'd500, 5'd2, 1'b0);
        send_entry(RANK_OTHER,  54'd500, 5'd3, 1'b0);
        send_entry(RANK_FIRST,  54'd9,   5'd4, 1'b0);
        send_entry(RANK_FIRST,  54'd9,   5'd5, 1'b0);
        send_entry(RANK_SECOND, 54'd1,   5'd6, 1'b0);
        send_entry(RANK_FIRST,  54'd8,   5'd7, 1'b0);
        send_entry(CAT_UNUSED,  54'd499, 5'd8, 1'b0);
        send_entry(RANK_FIRST,  54'd9,   5'd9, 1'b1);
    endtask

    task automatic test_full_row();
        send_random_set(CAPACITY);
    endtask

    task automatic test_overflow();
        int n;
        for (n = 0; n < CAPACITY + 2; n++)
            send_entry(random_category(), random_key(), HANDLE_BITS'($urandom), 1'b0);
        // final mark lands on a full row and is dropped too
        send_entry(random_category(), random_key(), HANDLE_BITS'($urandom), 1'b1);
        send_random_set(3);
    endtask

    task automatic test_random_sets(input int target);
        int sent;
        int size;
        int pick;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                size = $urandom_range(8, 1);
            else if (pick < 93)
                size = $urandom_range(CAPACITY - 1, 9);
            else
                size = $urandom_range(CAPACITY + 4, CAPACITY);
            send_random_set(size);
            sent += size;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(24, 66);
        test_extremes();
        test_stable_order();
        test_full_row();
        test_random_sets(30);

        set_idling(66, 24);
        test_overflow();
        test_random_sets(30);

        set_idling(0, 0);
        test_random_sets(20);

        in_valid <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
